// ----- hw/rtl/ray_cone_intersect_assert.svh -----
// assertion macros for the ray/cone intersection block
`ifndef RAY_CONE_INTERSECT_ASSERT_SVH
`define RAY_CONE_INTERSECT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define RCI_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define RCI_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rci_pkg.sv -----
// ----------------------------------------------------------------------------
// rci_pkg
// shared types, constants and helpers of the ray/cone intersection block
// ----------------------------------------------------------------------------
package rci_pkg;

  // ray class decided in the front, acted on in the back
  typedef enum logic [3:0] {
    CLS_MISS   = 4'b0001,
    CLS_FLAT   = 4'b0010,
    CLS_LINEAR = 4'b0100,
    CLS_QUAD   = 4'b1000
  } cls_e;

  // root extraction steps over a 128-bit radicand
  localparam int SQ_STEPS = 64;
  // quotient bits kept by a divider (overflow caught before the steps)
  localparam int DIV_QBITS = 33;
  // divider pipeline: operand stage, one stage per bit, saturation stage
  localparam int DIV_LAT = DIV_QBITS + 2;
  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // coefficients of one ray in cone space
  typedef struct packed {
    cls_e               cls;
    logic               acpos;
    logic signed [63:0] a;
    logic signed [63:0] h;
    logic signed [63:0] c;
    logic [63:0]        ma;
    logic [63:0]        mh;
    logic [63:0]        mc;
    logic signed [32:0] omz;
    logic signed [31:0] o2;
    logic signed [31:0] d2;
  } coef_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = Q_MAX;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] r;
    r = x[63] ? 64'(-x) : 64'(x);
    return r;
  endfunction

endpackage

// ----- hw/rtl/ray_cone_intersect.sv -----
// Ray against a transformed unit cone (base disc at z=0, apex at z=1), fixed
// point with FRAC_BITS fraction bits. The block takes one ray per clock and
// returns one result per clock when the output side keeps up. A ray passes
// through the front (transform and coefficients), the queue, then the
// discriminant, the pipelined square root, the pipelined dividers, and the z
// clip and result register. A 4-entry queue sits between front and back, so
// each side can stall on its own. The inverse transform rows (indexes 0 to 5)
// and the zero tolerance (index 6) are written through the configuration
// port, which is always ready; write them only while no ray is in flight.
// ----------------------------------------------------------------------------
// ray_cone_intersect
// top level: configuration registers, front, queue and back
// ----------------------------------------------------------------------------
module ray_cone_intersect import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] direction_x_i,
  input  logic signed [31:0] direction_y_i,
  input  logic signed [31:0] direction_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [31:0] ray_parameter_o
);

  localparam logic [2:0] RegRow0C01 = 3'd0;
  localparam logic [2:0] RegRow0C23 = 3'd1;
  localparam logic [2:0] RegRow1C01 = 3'd2;
  localparam logic [2:0] RegRow1C23 = 3'd3;
  localparam logic [2:0] RegRow2C01 = 3'd4;
  localparam logic [2:0] RegRow2C23 = 3'd5;
  localparam logic [2:0] RegZeroTol = 3'd6;

  logic [5:0][63:0] mat_q;
  logic [15:0]      tol_q;

  logic   push, pop;
  coef_t  coef_in, coef_out;
  qstat_t qstat;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[0] <= 64'h0000_0000_0001_0000;
      mat_q[1] <= 64'h0;
      mat_q[2] <= 64'h0001_0000_0000_0000;
      mat_q[3] <= 64'h0;
      mat_q[4] <= 64'h0;
      mat_q[5] <= 64'h0000_0000_0001_0000;
      tol_q    <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRow0C01: mat_q[0] <= cfg_data_i;
        RegRow0C23: mat_q[1] <= cfg_data_i;
        RegRow1C01: mat_q[2] <= cfg_data_i;
        RegRow1C23: mat_q[3] <= cfg_data_i;
        RegRow2C01: mat_q[4] <= cfg_data_i;
        RegRow2C23: mat_q[5] <= cfg_data_i;
        RegZeroTol: tol_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  rci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mat_i         (mat_q),
    .eps_i         (tol_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .origin_z_i    (origin_z_i),
    .direction_x_i (direction_x_i),
    .direction_y_i (direction_y_i),
    .direction_z_i (direction_z_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .coef_o        (coef_in)
  );

  rci_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (coef_in),
    .pop_i   (pop),
    .data_o  (coef_out),
    .qstat_o (qstat)
  );

  rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coef_i          (coef_out),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .ray_parameter_o (ray_parameter_o)
  );

endmodule

// ----- hw/rtl/rci_front.sv -----
// ----------------------------------------------------------------------------
// rci_front
// takes rays, maps them into cone space and classifies the quadratic
// ----------------------------------------------------------------------------
module rci_front import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [5:0][63:0]         mat_i,
  input  logic [15:0]              eps_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [31:0]       origin_x_i,
  input  logic signed [31:0]       origin_y_i,
  input  logic signed [31:0]       origin_z_i,
  input  logic signed [31:0]       direction_x_i,
  input  logic signed [31:0]       direction_y_i,
  input  logic signed [31:0]       direction_z_i,
  input  qstat_t                   qstat_i,
  output logic                     push_o,
  output coef_t                    coef_o
);

  localparam logic signed [32:0] One33 = 33'sd1 <<< FRAC_BITS;

  logic fen;
  logic signed [31:0] m [3][4];
  logic signed [31:0] wo [3];
  logic signed [31:0] wd [3];

  // stage 1: matrix products
  logic v1_q;
  logic signed [63:0] po_q [3][3];
  logic signed [63:0] pd_q [3][3];
  logic signed [31:0] tr_q [3];

  // stage 2: transformed ray
  logic v2_q;
  logic signed [31:0] o_q [3];
  logic signed [31:0] d_q [3];

  // stage 3: coefficient products
  logic v3_q;
  logic signed [63:0] sq_q [9];
  logic signed [32:0] omz3_q;
  logic signed [31:0] o2_3_q, d2_3_q;

  // stage 4: coefficients
  logic v4_q;
  logic signed [63:0] a_q, h_q, c_q;
  logic signed [32:0] omz4_q;
  logic signed [31:0] o2_4_q, d2_4_q;

  logic signed [32:0] omz;
  logic signed [65:0] omz_sq;
  logic signed [63:0] so [3];
  logic signed [63:0] sd [3];

  // the whole front moves unless its last beat is blocked by a full queue
  assign fen        = ~(v4_q & qstat_i.full);
  assign in_ready_o = fen;

  // unpack matrix entries, low half first
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        m[r][k] = mat_i[2*r + (k >> 1)][32*(k & 1) +: 32];
      end
    end
    wo[0] = origin_x_i;
    wo[1] = origin_y_i;
    wo[2] = origin_z_i;
    wd[0] = direction_x_i;
    wd[1] = direction_y_i;
    wd[2] = direction_z_i;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (fen) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1 products
  always_ff @(posedge clk_i) begin
    if (fen) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          po_q[r][k] <= m[r][k] * wo[k];
          pd_q[r][k] <= m[r][k] * wd[k];
        end
        tr_q[r] <= m[r][3];
      end
    end
  end

  // stage 2 sums with floor rescale and saturation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      so[r] = 64'(tr_q[r]) + (po_q[r][0] >>> FRAC_BITS) + (po_q[r][1] >>> FRAC_BITS)
            + (po_q[r][2] >>> FRAC_BITS);
      sd[r] = (pd_q[r][0] >>> FRAC_BITS) + (pd_q[r][1] >>> FRAC_BITS)
            + (pd_q[r][2] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      for (int r = 0; r < 3; r++) begin
        o_q[r] <= sat32(so[r]);
        d_q[r] <= sat32(sd[r]);
      end
    end
  end

  // stage 3 squares and cross terms
  assign omz    = One33 - 33'(o_q[2]);
  assign omz_sq = omz * omz;

  always_ff @(posedge clk_i) begin
    if (fen) begin
      sq_q[0] <= d_q[0] * d_q[0];
      sq_q[1] <= d_q[1] * d_q[1];
      sq_q[2] <= d_q[2] * d_q[2];
      sq_q[3] <= o_q[0] * d_q[0];
      sq_q[4] <= o_q[1] * d_q[1];
      sq_q[5] <= o_q[2] * d_q[2];
      sq_q[6] <= o_q[0] * o_q[0];
      sq_q[7] <= o_q[1] * o_q[1];
      sq_q[8] <= $signed(omz_sq[63:0]);
      omz3_q  <= omz;
      o2_3_q  <= o_q[2];
      d2_3_q  <= d_q[2];
    end
  end

  // stage 4 coefficients a, h (half of b) and c
  always_ff @(posedge clk_i) begin
    if (fen) begin
      a_q <= (sq_q[0] >>> FRAC_BITS) + (sq_q[1] >>> FRAC_BITS) - (sq_q[2] >>> FRAC_BITS);
      h_q <= (sq_q[3] >>> FRAC_BITS) + (sq_q[4] >>> FRAC_BITS) - (sq_q[5] >>> FRAC_BITS)
           + 64'(d2_3_q);
      c_q <= (sq_q[6] >>> FRAC_BITS) + (sq_q[7] >>> FRAC_BITS) - (sq_q[8] >>> FRAC_BITS);
      omz4_q <= omz3_q;
      o2_4_q <= o2_3_q;
      d2_4_q <= d2_3_q;
    end
  end

  // classification against the zero tolerance
  always_comb begin
    logic [63:0] eps64;
    logic        small_a, small_b, small_c;
    eps64   = 64'(eps_i);
    coef_o.a     = a_q;
    coef_o.h     = h_q;
    coef_o.c     = c_q;
    coef_o.ma    = mag64(a_q);
    coef_o.mh    = mag64(h_q);
    coef_o.mc    = mag64(c_q);
    coef_o.omz   = omz4_q;
    coef_o.o2    = o2_4_q;
    coef_o.d2    = d2_4_q;
    coef_o.acpos = (a_q != 64'sd0) && (c_q != 64'sd0) && (a_q[63] == c_q[63]);
    small_a = coef_o.ma < eps64;
    small_b = mag64(h_q <<< 1) < eps64;
    small_c = coef_o.mc <= eps64;
    if (!small_a) begin
      coef_o.cls = CLS_QUAD;
    end else if (!small_b) begin
      coef_o.cls = CLS_LINEAR;
    end else if (small_c) begin
      coef_o.cls = CLS_FLAT;
    end else begin
      coef_o.cls = CLS_MISS;
    end
  end

  assign push_o = v4_q & fen;

endmodule

// ----- hw/rtl/rci_queue.sv -----
// ----------------------------------------------------------------------------
// rci_queue
// short queue that decouples the front from the back
// ----------------------------------------------------------------------------
module rci_queue import rci_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  coef_t  data_i,
  input  logic   pop_i,
  output coef_t  data_o,
  output qstat_t qstat_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  coef_t             slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign qstat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign data_o        = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/rci_div.sv -----
// ----------------------------------------------------------------------------
// rci_div
// pipelined saturating fixed-point divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rci_div import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [65:0] num_i,
  input  logic signed [63:0] den_i,
  output logic signed [31:0] quo_o
);

  localparam int NW = 66 + FRAC_BITS;
  localparam int QB = DIV_QBITS;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic dz;
    logic npos;
    logic nneg;
  } dflag_t;

  logic [65:0]    mn;
  logic [63:0]    md;
  logic [NW-1:0]  nfull;
  logic [NW-QB-1:0] nhi;
  dflag_t         fl_in;

  logic [63:0]    rem_q [QB+1];
  logic [QB-1:0]  lo_q  [QB+1];
  logic [QB-1:0]  quo_q [QB+1];
  logic [63:0]    d_q   [QB+1];
  dflag_t         fl_q  [QB+1];
  logic signed [31:0] res_q;

  // operand preparation and early overflow test
  always_comb begin
    mn          = num_i[65] ? 66'(-num_i) : 66'(num_i);
    md          = mag64(den_i);
    nfull       = NW'(mn) << FRAC_BITS;
    nhi         = nfull[NW-1:QB];
    fl_in.neg   = num_i[65] ^ den_i[63];
    fl_in.ovf   = 64'(nhi) >= md;
    fl_in.dz    = (den_i == 64'sd0);
    fl_in.npos  = !num_i[65] && (num_i != 66'sd0);
    fl_in.nneg  = num_i[65];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= 64'(nhi);
      lo_q[0]  <= nfull[QB-1:0];
      quo_q[0] <= '0;
      d_q[0]   <= md;
      fl_q[0]  <= fl_in;
    end
  end

  // restoring steps
  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [64:0] r2, diff;
    logic        ge;
    assign r2   = {rem_q[i-1], lo_q[i-1][QB-1]};
    assign diff = r2 - {1'b0, d_q[i-1]};
    assign ge   = r2 >= {1'b0, d_q[i-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[63:0] : r2[63:0];
        lo_q[i]  <= lo_q[i-1] << 1;
        quo_q[i] <= {quo_q[i-1][QB-2:0], ge};
        d_q[i]   <= d_q[i-1];
        fl_q[i]  <= fl_q[i-1];
      end
    end
  end

  // saturation and sign
  always_ff @(posedge clk_i) begin
    logic [QB-1:0] limit;
    limit = fl_q[QB].neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
    if (en_i) begin
      if (fl_q[QB].dz) begin
        res_q <= fl_q[QB].npos ? Q_MAX : (fl_q[QB].nneg ? Q_MIN : 32'sd0);
      end else if (fl_q[QB].ovf || (quo_q[QB] > limit)) begin
        res_q <= fl_q[QB].neg ? Q_MIN : Q_MAX;
      end else begin
        res_q <= fl_q[QB].neg ? $signed(32'd0 - quo_q[QB][31:0]) : $signed(quo_q[QB][31:0]);
      end
    end
  end

  assign quo_o = res_q;

endmodule

// ----- hw/rtl/rci_back.sv -----
// ----------------------------------------------------------------------------
// rci_back
// discriminant, root, divisions, z clip and result register
// ----------------------------------------------------------------------------
module rci_back import rci_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  coef_t              coef_i,
  input  qstat_t             qstat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic signed [31:0] ray_parameter_o
);

  localparam logic signed [63:0] One64 = 64'sd1 <<< FRAC_BITS;

  typedef struct packed {
    cls_e               cls;
    logic               ok;
    logic signed [63:0] a;
    logic signed [63:0] h;
    logic signed [63:0] c;
    logic signed [32:0] omz;
    logic signed [31:0] o2;
    logic signed [31:0] d2;
  } side_t;

  typedef struct packed {
    cls_e               cls;
    logic               ok;
    logic signed [31:0] o2;
    logic signed [31:0] d2;
  } tail_t;

  function automatic logic signed [31:0] min32(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    return (x < y) ? x : y;
  endfunction

  logic en;

  logic        b1_v_q, b2_v_q, b3_v_q;
  coef_t       b1_q, b2_q, b3_q;
  logic [63:0] pp_q [7];
  logic [127:0] hh_q, ac_q;

  logic         sq_v_q    [SQ_STEPS+1];
  logic [66:0]  sq_rem_q  [SQ_STEPS+1];
  logic [63:0]  sq_root_q [SQ_STEPS+1];
  logic [127:0] sq_rad_q  [SQ_STEPS+1];
  side_t        sq_side_q [SQ_STEPS+1];

  logic               tl_v_q [DIV_LAT];
  tail_t              tl_q   [DIV_LAT];

  logic signed [65:0] num_a, num_b, num_t;
  logic signed [63:0] den_a, den_b, den_t;
  logic signed [31:0] qa, qb, qt;

  logic               z_v_q;
  tail_t              z_tl_q;
  logic signed [63:0] pz0_q, pz1_q;
  logic signed [31:0] qa_q, qb_q, qt_q;

  logic               out_v_q, hit_q;
  logic signed [31:0] par_q;
  logic               hit_d;
  logic signed [31:0] par_d;

  // the back moves whenever the result register is free or being taken
  assign en    = ~out_v_q | out_ready_i;
  assign pop_o = en & ~qstat_i.empty;

  // valid chain outside the long stage arrays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q      <= 1'b0;
      b2_v_q      <= 1'b0;
      b3_v_q      <= 1'b0;
      sq_v_q[0]   <= 1'b0;
      tl_v_q[0]   <= 1'b0;
      z_v_q       <= 1'b0;
      out_v_q     <= 1'b0;
    end else if (en) begin
      b1_v_q      <= ~qstat_i.empty;
      b2_v_q      <= b1_v_q;
      b3_v_q      <= b2_v_q;
      sq_v_q[0]   <= b3_v_q;
      tl_v_q[0]   <= sq_v_q[SQ_STEPS];
      z_v_q       <= tl_v_q[DIV_LAT-1];
      out_v_q     <= z_v_q;
    end
  end

  // pop, partial products of h*h and a*c, then the full products
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q     <= coef_i;
      b2_q     <= b1_q;
      pp_q[0]  <= b1_q.mh[31:0] * b1_q.mh[31:0];
      pp_q[1]  <= b1_q.mh[31:0] * b1_q.mh[63:32];
      pp_q[2]  <= b1_q.mh[63:32] * b1_q.mh[63:32];
      pp_q[3]  <= b1_q.ma[31:0] * b1_q.mc[31:0];
      pp_q[4]  <= b1_q.ma[31:0] * b1_q.mc[63:32];
      pp_q[5]  <= b1_q.ma[63:32] * b1_q.mc[31:0];
      pp_q[6]  <= b1_q.ma[63:32] * b1_q.mc[63:32];
      b3_q     <= b2_q;
      hh_q     <= {pp_q[2], 64'd0} + (128'(pp_q[1]) << 33) + 128'(pp_q[0]);
      ac_q     <= {pp_q[6], 64'd0} + (128'(pp_q[4]) << 32) + (128'(pp_q[5]) << 32)
                + 128'(pp_q[3]);
    end
  end

  // discriminant, loaded as the radicand of the root pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]       <= '0;
      sq_root_q[0]      <= '0;
      sq_side_q[0].cls  <= b3_q.cls;
      sq_side_q[0].a    <= b3_q.a;
      sq_side_q[0].h    <= b3_q.h;
      sq_side_q[0].c    <= b3_q.c;
      sq_side_q[0].omz  <= b3_q.omz;
      sq_side_q[0].o2   <= b3_q.o2;
      sq_side_q[0].d2   <= b3_q.d2;
      if (!b3_q.acpos) begin
        sq_rad_q[0]     <= hh_q + ac_q;
        sq_side_q[0].ok <= 1'b1;
      end else if (hh_q < ac_q) begin
        sq_rad_q[0]     <= hh_q;
        sq_side_q[0].ok <= 1'b0;
      end else begin
        sq_rad_q[0]     <= hh_q - ac_q;
        sq_side_q[0].ok <= 1'b1;
      end
    end
  end

  // integer square root, two radicand bits per stage
  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    logic [66:0] rem_sh, trial;
    logic        ge;
    assign rem_sh = {sq_rem_q[k-1][64:0], sq_rad_q[k-1][127:126]};
    assign trial  = {1'b0, sq_root_q[k-1], 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= sq_v_q[k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_q[k] <= {sq_root_q[k-1][62:0], ge};
        sq_rad_q[k]  <= sq_rad_q[k-1] << 2;
        sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // divider operands by class
  always_comb begin
    side_t              sd;
    logic signed [65:0] s66, h66;
    sd    = sq_side_q[SQ_STEPS];
    s66   = $signed({2'b00, sq_root_q[SQ_STEPS]});
    h66   = 66'(sd.h);
    num_t = -66'(sd.o2);
    den_t = 64'(sd.d2);
    num_b = -h66 + s66;
    den_b = sd.a;
    case (sd.cls)
      CLS_QUAD: begin
        num_a = -h66 - s66;
        den_a = sd.a;
      end
      CLS_FLAT: begin
        num_a = 66'(sd.omz);
        den_a = 64'(sd.d2);
      end
      CLS_LINEAR: begin
        num_a = -66'(sd.c);
        den_a = sd.h <<< 1;
      end
      default: begin
        num_a = '0;
        den_a = '0;
      end
    endcase
  end

  rci_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk_i (clk_i), .en_i (en), .num_i (num_a), .den_i (den_a), .quo_o (qa)
  );
  rci_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk_i (clk_i), .en_i (en), .num_i (num_b), .den_i (den_b), .quo_o (qb)
  );
  rci_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
    .clk_i (clk_i), .en_i (en), .num_i (num_t), .den_i (den_t), .quo_o (qt)
  );

  // side data riding along with the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      tl_q[0].cls <= sq_side_q[SQ_STEPS].cls;
      tl_q[0].ok  <= sq_side_q[SQ_STEPS].ok;
      tl_q[0].o2  <= sq_side_q[SQ_STEPS].o2;
      tl_q[0].d2  <= sq_side_q[SQ_STEPS].d2;
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_tail
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tl_v_q[j] <= 1'b0;
      end else if (en) begin
        tl_v_q[j] <= tl_v_q[j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        tl_q[j] <= tl_q[j-1];
      end
    end
  end

  // hit height products
  always_ff @(posedge clk_i) begin
    if (en) begin
      z_tl_q <= tl_q[DIV_LAT-1];
      pz0_q  <= tl_q[DIV_LAT-1].d2 * qa;
      pz1_q  <= tl_q[DIV_LAT-1].d2 * qb;
      qa_q   <= qa;
      qb_q   <= qb;
      qt_q   <= qt;
    end
  end

  // z clip and result selection
  always_comb begin
    logic signed [63:0] z0, z1;
    logic               in0, in1;
    z0    = 64'(z_tl_q.o2) + (pz0_q >>> FRAC_BITS);
    z1    = 64'(z_tl_q.o2) + (pz1_q >>> FRAC_BITS);
    in0   = (z0 > 64'sd0) && (z0 < One64);
    in1   = (z1 > 64'sd0) && (z1 < One64);
    hit_d = 1'b0;
    par_d = 32'sd0;
    case (z_tl_q.cls)
      CLS_QUAD: begin
        if (!z_tl_q.ok) begin
          hit_d = 1'b0;
        end else if (((z0 > One64) && (z1 > One64)) || ((z0 < 64'sd0) && (z1 < 64'sd0))) begin
          hit_d = 1'b0;
        end else if (in0 && in1) begin
          hit_d = 1'b1;
          par_d = min32(qa_q, qb_q);
        end else if (in0) begin
          hit_d = 1'b1;
          par_d = min32(qa_q, qt_q);
        end else if (in1) begin
          hit_d = 1'b1;
          par_d = min32(qt_q, qb_q);
        end
      end
      CLS_FLAT, CLS_LINEAR: begin
        hit_d = 1'b1;
        par_d = min32(qt_q, qa_q);
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
      par_q <= par_d;
    end
  end

  assign out_valid_o     = out_v_q;
  assign hit_o           = hit_q;
  assign ray_parameter_o = par_q;

endmodule

// ----- hw/rtl/rci_checker.sv -----
// ----------------------------------------------------------------------------
// rci_checker
// port-level checks on the result channel of the intersection block
// ----------------------------------------------------------------------------
`include "ray_cone_intersect_assert.svh"

module rci_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               hit_o,
  input logic signed [31:0] ray_parameter_o
);

  // a stalled result beat stays up
  `RCI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")

  // a stalled result beat keeps its payload
  `RCI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(hit_o) && $stable(ray_parameter_o), "result payload changed while stalled")

  // a miss carries a zero parameter
  `RCI_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o, ray_parameter_o == 32'sd0, "miss with nonzero parameter")

  // no result right after reset release
  `RCI_ASSERT_NOW(a_reset_quiet, clk_i, rst_ni, $past(!rst_ni), !out_valid_o, "result beat right after reset")

endmodule

bind ray_cone_intersect rci_checker u_rci_checker (.*);
